FILE: rtl/sha256_stream_hasher_macros.svh
// Assertion macros used by the checker file.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/sha256_pkg.sv
// Types and constants of the SHA-256 stream hasher.
package sha256_pkg;
    typedef struct packed {
        logic absorb;     // write the accepted byte into the block
        logic pad_byte;   // write one padding byte at the fill position
        logic pad_mark;   // the padding byte is 0x80 rather than zero
        logic put_len;    // write the bit length into words 14 and 15
        logic clr_blk;    // zero the whole block
        logic comp_start; // load working variables from the chaining words
        logic round;      // run one round
        logic comp_fin;   // fold working variables into the chaining words
        logic reset_msg;  // restore the initial state
        logic load_out;   // load the output register with a digest word
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] fill;       // bytes in the current block
        logic [5:0] round_idx;  // current round number
    } sha_stat_t;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

FILE: rtl/sha256_datapath.sv
// Block buffer, message schedule, round logic and chaining words.
module sha256_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sha256_pkg::sha_cmd_t cmd,
    output sha256_pkg::sha_stat_t stat,
    input  logic [7:0]           in_byte,
    input  logic [2:0]           out_idx,
    output logic [31:0]          out_word_reg
);
    import sha256_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [5:0]  rnd_reg;
    logic [60:0] count_reg;

    logic [31:0] w_new, t1, t2, s0, s1, b1, b0, ch, mj;
    logic [7:0]  wr_byte;
    logic [3:0]  wsel;
    logic [4:0]  sh;

    assign stat.fill      = fill_reg;
    assign stat.round_idx = rnd_reg;
    assign wr_byte = cmd.absorb ? in_byte : (cmd.pad_mark ? PadByte : 8'h00);
    assign wsel    = fill_reg[5:2];
    assign sh      = {~fill_reg[1:0], 3'b000};

    always_comb begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        b1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + b1 + ch + RoundK[rnd_reg] + w_reg[0];
        b0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = b0 + mj;
    end

    // The block store doubles as the schedule window: it shifts one word per round.
    always_ff @(posedge aclk) begin
        if (cmd.clr_blk) begin
            for (int i = 0; i < 16; i++) w_reg[i] <= '0;
        end else if (cmd.round) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
        end else if (cmd.put_len) begin
            w_reg[14] <= {count_reg[60:29]};
            w_reg[15] <= {count_reg[28:0], 3'b000};
        end else if (cmd.absorb || cmd.pad_byte) begin
            w_reg[wsel] <= (w_reg[wsel] & ~(32'hff << sh)) | ({24'd0, wr_byte} << sh);
        end
        if (cmd.comp_start) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end else if (cmd.round) begin
            v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.load_out) out_word_reg <= h_reg[out_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reset_msg) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= InitH[i];
            fill_reg  <= '0;
            rnd_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.comp_fin) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (cmd.absorb) begin
                fill_reg  <= fill_reg + 6'd1;
                count_reg <= count_reg + 61'd1;
            end else if (cmd.pad_byte) begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.comp_start) rnd_reg <= '0;
            else if (cmd.round) rnd_reg <= rnd_reg + 6'd1;
        end
    end
endmodule

FILE: rtl/sha256_ctrl.sv
// Sequencer for absorption, padding, compression and digest output.
module sha256_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  in_has,
    input  logic                  in_end,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2:0]            out_idx_reg,
    output sha256_pkg::sha_cmd_t  cmd,
    input  sha256_pkg::sha_stat_t stat
);
    import sha256_pkg::*;

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StPad   = 3'd1;
    localparam logic [2:0] StRound = 3'd2;
    localparam logic [2:0] StFin   = 3'd3;
    localparam logic [2:0] StOut   = 3'd4;
    localparam logic [2:0] StLen   = 3'd5;
    localparam logic [2:0] StStart = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       fin_reg, fin_next;   // closing the message
    logic       lenb_reg, lenb_next; // current block carries the length
    logic       mark_reg, mark_next; // the 0x80 byte is still to be written
    logic [2:0] idx_next;
    logic       mv_next;
    logic       acc;

    assign s_tready = (state_reg == StIdle);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        fin_next   = fin_reg;
        lenb_next  = lenb_reg;
        mark_next  = mark_reg;
        idx_next   = out_idx_reg;
        mv_next    = m_tvalid;
        case (state_reg)
            StIdle: begin
                if (acc) begin
                    cmd.absorb = in_has;
                    fin_next   = in_end;
                    lenb_next  = 1'b0;
                    mark_next  = in_end;
                    if (in_has && stat.fill == 6'd63) state_next = StStart;
                    else if (in_end) state_next = StPad;
                end
            end
            StPad: begin
                // The 0x80 byte is written first, then zeros up to the length
                // field, or up to the block end when the length does not fit.
                cmd.pad_byte = 1'b1;
                cmd.pad_mark = mark_reg;
                mark_next    = 1'b0;
                if (stat.fill == 6'd63) state_next = StStart;
                else if (stat.fill == LenPos - 6'd1) state_next = StLen;
            end
            StLen: begin
                cmd.put_len = 1'b1;
                state_next  = StStart;
                lenb_next   = 1'b1;
            end
            StStart: begin
                cmd.comp_start = 1'b1;
                state_next     = StRound;
            end
            StRound: begin
                cmd.round = 1'b1;
                if (stat.round_idx == 6'd63) state_next = StFin;
            end
            StFin: begin
                cmd.comp_fin = 1'b1;
                if (!fin_reg) begin
                    state_next = StIdle;
                end else if (lenb_reg) begin
                    idx_next   = '0;
                    state_next = StOut;
                end else if (mark_reg) begin
                    // The message ended on a full block, so padding opens a new one.
                    state_next = StPad;
                end else begin
                    cmd.clr_blk = 1'b1;
                    state_next  = StLen;
                end
            end
            StOut: begin
                if (!m_tvalid || m_tready) begin
                    if (m_tvalid && out_idx_reg == 3'd7) begin
                        mv_next       = 1'b0;
                        cmd.reset_msg = 1'b1;
                        state_next    = StIdle;
                    end else begin
                        cmd.load_out = 1'b1;
                        mv_next      = 1'b1;
                        if (m_tvalid) idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= StIdle;
            fin_reg     <= 1'b0;
            lenb_reg    <= 1'b0;
            mark_reg    <= 1'b0;
            out_idx_reg <= '0;
            m_tvalid    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fin_reg     <= fin_next;
            lenb_reg    <= lenb_next;
            mark_reg    <= mark_next;
            out_idx_reg <= idx_next;
            m_tvalid    <= mv_next;
        end
    end
endmodule

FILE: rtl/sha256_stream_hasher.sv
// Top level of the byte-stream SHA-256 hasher.
//
// Input channel s_*: one request per byte. tdata holds data_byte; tuser
// holds has_byte (bit 0); tlast is end_of_message. A request with tlast
// closes the message and may carry a final byte when has_byte is set.
// Output channel m_*: eight digest words per message, H0 first. tdata holds
// digest_word (bits 31:0) then word_index (34:32); tlast marks the eighth.
// Bytes are taken one per cycle while s_tready is high; every 64th byte
// starts the 64-round compression, one round per cycle in a single round
// unit. A message end adds padding, the length, one or two compressions
// and the eight output words.
// s_tready is low from a block's last byte until its compression ends,
// and during padding and digest output. A stalled receiver holds the
// current word; the block waits until all eight are taken.
// Reset (aresetn low, synchronous) restores the initial hash values and
// clears the counters; requests are taken once reset is released.
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] data_byte
    input  logic        s_tuser,  // [0] has_byte
    input  logic        s_tlast,  // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast   // last_word
);
    import sha256_pkg::*;

    sha_cmd_t   cmd;
    sha_stat_t  stat;
    logic [2:0] idx;
    logic [31:0] word;

    sha256_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .in_has(s_tuser), .in_end(s_tlast),
        .m_tvalid, .m_tready, .out_idx_reg(idx), .cmd, .stat
    );

    sha256_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat, .in_byte(s_tdata),
        .out_idx(cmd.load_out && m_tvalid ? idx + 3'd1 : idx), .out_word_reg(word)
    );

    assign m_tdata = {5'd0, idx, word};
    assign m_tlast = (idx == 3'd7);
endmodule

FILE: rtl/sha256_checker.sv
// Port-level checker for the hasher, bound to the top level.
`include "sha256_stream_hasher_macros.svh"
module sha256_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    `SHA_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "input open during output")
    `SHA_ASSERT_IMPL(a_last_idx, aclk, aresetn, m_tvalid, m_tlast == (m_tdata[34:32] == 3'd7), "tlast mismatch")
    `SHA_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled word changed")
    `SHA_ASSERT_NEXT(a_idx_step, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1, "index skipped")
endmodule

bind sha256_stream_hasher sha256_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
